>>> hw/rtl/bdn_pkg.sv
// ----------------------------------------------------------------------------
// bdn_pkg: shared types and constants for the button debounce and axis core
// Field widths, register indexes, reset values and control state types.
// ----------------------------------------------------------------------------
package bdn_pkg;

  localparam int BUTTONS_DEF = 8;
  localparam int PIN_W       = 8;
  localparam int TIME_W      = 63;
  localparam int CNT_W       = $clog2(TIME_W);
  localparam int MS_W        = 16;
  localparam int WAIT_W      = 26;
  localparam int SAMPLE_W    = 12;
  localparam int CAL_W       = 36;
  localparam int DZ_W        = 15;
  localparam int AXIS_W      = 16;
  localparam int FRAC_W      = 14;
  localparam int MAG_W       = SAMPLE_W + FRAC_W;
  localparam int DCNT_W      = $clog2(MAG_W);
  localparam int IDX_W       = 3;

  localparam logic [WAIT_W-1:0] US_PER_MS = WAIT_W'(1000);
  localparam logic [MAG_W-1:0]  QONE      = MAG_W'(16384);

  localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVE_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BUTTON_MASK = 3'd2;
  localparam logic [IDX_W-1:0] REG_AXIS_ENABLE = 3'd3;
  localparam logic [IDX_W-1:0] REG_X_CAL       = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_CAL       = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEADZONE    = 3'd6;

  localparam logic [MS_W-1:0]  DEBOUNCE_RST    = 16'd20;
  localparam logic             ACTIVE_LOW_RST  = 1'b1;
  localparam logic [PIN_W-1:0] MASK_RST        = 8'hFF;
  localparam logic [1:0]       AXIS_EN_RST     = 2'b00;
  localparam logic [CAL_W-1:0] CAL_RST         = 36'hFFF800000;
  localparam logic [DZ_W-1:0]  DEADZONE_RST    = 15'd1638;

  typedef struct packed {
    logic [PIN_W-1:0] held;
    logic [PIN_W-1:0] went_down;
    logic [PIN_W-1:0] went_up;
  } btn_status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_PUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_XGO,
    AS_XRUN,
    AS_YGO,
    AS_YRUN
  } axis_state_t;

endpackage

>>> hw/rtl/bdn_debounce.sv
// ----------------------------------------------------------------------------
// bdn_debounce: bit-serial debounce lanes
// Each lane subtracts its change time from the tick time one bit per cycle
// and compares the elapsed time with the debounce wait, LSB first.
// ----------------------------------------------------------------------------
module bdn_debounce #(
  parameter int BUTTONS = bdn_pkg::BUTTONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bdn_pkg::TIME_W-1:0]  now,
  input  logic [bdn_pkg::PIN_W-1:0]   pins,
  input  logic                        active_low,
  input  logic [bdn_pkg::PIN_W-1:0]   button_mask,
  input  logic [bdn_pkg::MS_W-1:0]    debounce_ms,
  output logic                        done,
  output bdn_pkg::btn_status_t        status
);
  import bdn_pkg::*;

  logic [BUTTONS-1:0] pressed_in, pressed_q, changed, last_raw;
  logic [BUTTONS-1:0] stable_now, stable_before;
  logic [BUTTONS-1:0] borrow, borrow_next, ge, ge_next, ct_in;
  logic [TIME_W-1:0]  change_time [BUTTONS];
  logic [TIME_W-1:0]  now_sr, wait_sr;
  logic [WAIT_W-1:0]  wait_us;
  logic [CNT_W-1:0]   cnt;
  logic               busy, fin;

  assign wait_us = WAIT_W'(debounce_ms) * US_PER_MS;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    if (i < PIN_W) begin : g_pin
      assign pressed_in[i] = button_mask[i] & (pins[i] ^ active_low);
    end else begin : g_nopin
      assign pressed_in[i] = 1'b0;
    end
  end

  always_comb begin
    logic a, b, w, d;
    a = now_sr[0];
    w = wait_sr[0];
    for (int i = 0; i < BUTTONS; i++) begin
      b = change_time[i][0];
      d = a ^ b ^ borrow[i];
      borrow_next[i] = (~a & b) | (~(a ^ b) & borrow[i]);
      if (d & ~w) begin
        ge_next[i] = 1'b1;
      end else if (~d & w) begin
        ge_next[i] = 1'b0;
      end else begin
        ge_next[i] = ge[i];
      end
      ct_in[i] = changed[i] ? a : b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      fin           <= 1'b0;
      done          <= 1'b0;
      last_raw      <= '0;
      stable_now    <= '0;
      stable_before <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        change_time[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (start) begin
        now_sr    <= now;
        wait_sr   <= TIME_W'(wait_us);
        pressed_q <= pressed_in;
        changed   <= pressed_in ^ last_raw;
        last_raw  <= pressed_in;
        borrow    <= '0;
        ge        <= '1;
        cnt       <= '0;
        busy      <= 1'b1;
      end else if (busy) begin
        now_sr  <= now_sr >> 1;
        wait_sr <= wait_sr >> 1;
        borrow  <= borrow_next;
        ge      <= ge_next;
        for (int i = 0; i < BUTTONS; i++) begin
          change_time[i] <= {ct_in[i], change_time[i][TIME_W-1:1]};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        for (int i = 0; i < BUTTONS; i++) begin
          if (!changed[i] && ge[i]) begin
            stable_before[i] <= stable_now[i];
            stable_now[i]    <= pressed_q[i];
          end
        end
      end
    end
  end

  for (genvar j = 0; j < PIN_W; j++) begin : g_out
    if (j < BUTTONS) begin : g_used
      assign status.held[j]      = stable_now[j];
      assign status.went_down[j] = stable_now[j] & ~stable_before[j];
      assign status.went_up[j]   = ~stable_now[j] & stable_before[j];
    end else begin : g_unused
      assign status.held[j]      = 1'b0;
      assign status.went_down[j] = 1'b0;
      assign status.went_up[j]   = 1'b0;
    end
  end

endmodule

>>> hw/rtl/bdn_serial_div.sv
// ----------------------------------------------------------------------------
// bdn_serial_div: restoring divider, one quotient bit per cycle
// Divides the scaled distance by the span; the divisor is never zero.
// ----------------------------------------------------------------------------
module bdn_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bdn_pkg::MAG_W-1:0]     dividend,
  input  logic [bdn_pkg::SAMPLE_W-1:0]  divisor,
  output logic                          done,
  output logic [bdn_pkg::MAG_W-1:0]     quotient
);
  import bdn_pkg::*;

  logic [SAMPLE_W-1:0] rem, dvs;
  logic [SAMPLE_W:0]   rem_sh, rem_sub;
  logic                take;
  logic [DCNT_W-1:0]   cnt;
  logic                busy;

  assign rem_sh  = {rem, quotient[MAG_W-1]};
  assign take    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= take ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
        quotient <= {quotient[MAG_W-2:0], take};
        cnt      <= cnt + 1'b1;
        if (cnt == DCNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/bdn_axis.sv
// ----------------------------------------------------------------------------
// bdn_axis: joystick axis scaling sequencer
// Runs X then Y through one shared divider, applies deadzone and clamp.
// ----------------------------------------------------------------------------
module bdn_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [bdn_pkg::SAMPLE_W-1:0]        x_sample,
  input  logic [bdn_pkg::SAMPLE_W-1:0]        y_sample,
  input  logic [1:0]                          axis_enable,
  input  logic [bdn_pkg::CAL_W-1:0]           x_cal,
  input  logic [bdn_pkg::CAL_W-1:0]           y_cal,
  input  logic [bdn_pkg::DZ_W-1:0]            deadzone,
  output logic                                done,
  output logic signed [bdn_pkg::AXIS_W-1:0]   axis_x,
  output logic signed [bdn_pkg::AXIS_W-1:0]   axis_y
);
  import bdn_pkg::*;

  axis_state_t state, state_next;

  logic [SAMPLE_W-1:0] xs, ys, smp, lo, mid, hi, delta, divisor;
  logic [CAL_W-1:0]    cal;
  logic [SAMPLE_W:0]   span;
  logic                sel_y, upper, empty;
  logic                div_start, div_done, wr_x, wr_y;
  logic [MAG_W-1:0]    quotient;
  logic [AXIS_W-1:0]   mag16, value;

  assign sel_y   = state inside {AS_YGO, AS_YRUN};
  assign smp     = sel_y ? ys : xs;
  assign cal     = sel_y ? y_cal : x_cal;
  assign lo      = cal[SAMPLE_W-1:0];
  assign mid     = cal[2*SAMPLE_W-1:SAMPLE_W];
  assign hi      = cal[3*SAMPLE_W-1:2*SAMPLE_W];
  assign upper   = smp >= mid;
  assign span    = upper ? ({1'b0, hi} - {1'b0, mid}) : ({1'b0, mid} - {1'b0, lo});
  assign delta   = upper ? (smp - mid) : (mid - smp);
  assign empty   = span[SAMPLE_W] || (span == '0);
  assign divisor = empty ? SAMPLE_W'(1) : span[SAMPLE_W-1:0];

  bdn_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({delta, {FRAC_W{1'b0}}}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    mag16 = (quotient > QONE) ? QONE[AXIS_W-1:0] : quotient[AXIS_W-1:0];
    if (empty || (quotient < MAG_W'(deadzone))) begin
      value = '0;
    end else if (upper) begin
      value = mag16;
    end else begin
      value = AXIS_W'(0) - mag16;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      AS_IDLE: if (start) state_next = AS_XGO;
      AS_XGO:  state_next = AS_XRUN;
      AS_XRUN: if (div_done) state_next = AS_YGO;
      AS_YGO:  state_next = AS_YRUN;
      AS_YRUN: if (div_done) state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    wr_x      = 1'b0;
    wr_y      = 1'b0;
    done      = 1'b0;
    case (state)
      AS_XGO, AS_YGO: div_start = 1'b1;
      AS_XRUN: wr_x = div_done & axis_enable[0];
      AS_YRUN: begin
        wr_y = div_done & axis_enable[1];
        done = div_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= AS_IDLE;
      axis_x <= '0;
      axis_y <= '0;
    end else begin
      state <= state_next;
      if (state == AS_IDLE && start) begin
        xs <= x_sample;
        ys <= y_sample;
      end
      if (wr_x) axis_x <= value;
      if (wr_y) axis_y <= value;
    end
  end

endmodule

>>> hw/rtl/button_debounce_and_axis_normalizer_core.sv
// ----------------------------------------------------------------------------
// button_debounce_and_axis_normalizer_core: button debounce and joystick axes
// Takes one tick per transfer on the s_axis side and returns one status
// transfer on the m_axis side: debounced button state with press and release
// edges, and both joystick axes normalised to signed Q2.14 while enabled.
//
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata. The user
// must write it only while the core is idle; the core itself does not enforce
// this. A write to an unused index is dropped.
//
// The time per tick is set by the 63-step bit-serial elapsed-time compare
// that runs on all button lanes at once; the two axis divisions share one
// radix-2 divider (26 steps each) and run alongside it.
//
// Reset (rst, synchronous) restores the register defaults, clears the
// debounce state, change times and axis positions; the time base starts at
// zero. The finished result sits in an output register; while the receiver
// stalls it holds, and a later result is loaded only once it has been sent.
// ----------------------------------------------------------------------------
module button_debounce_and_axis_normalizer_core #(
  parameter int BUTTONS = bdn_pkg::BUTTONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // time_us [62:0], pin_levels [70:63], joy_x_sample [82:71],
  // joy_y_sample [94:83], zero [95]
  input  logic [95:0]                 s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // held [7:0], went_down [15:8], went_up [23:16], axis_x [39:24],
  // axis_y [55:40]
  output logic [55:0]                 m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        cfg_wr_en,
  input  logic [bdn_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [bdn_pkg::CAL_W-1:0]   cfg_wdata
);
  import bdn_pkg::*;

  ctrl_state_t state, state_next;

  logic [MS_W-1:0]    debounce_ms;
  logic               active_low;
  logic [PIN_W-1:0]   button_mask;
  logic [1:0]         axis_enable;
  logic [CAL_W-1:0]   x_cal, y_cal;
  logic [DZ_W-1:0]    deadzone;

  logic               start, load_out;
  logic               deb_done, ax_done, deb_seen, ax_seen;
  btn_status_t        status;
  logic signed [AXIS_W-1:0] axis_x, axis_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RST;
      active_low  <= ACTIVE_LOW_RST;
      button_mask <= MASK_RST;
      axis_enable <= AXIS_EN_RST;
      x_cal       <= CAL_RST;
      y_cal       <= CAL_RST;
      deadzone    <= DEADZONE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DEBOUNCE_MS: debounce_ms <= cfg_wdata[MS_W-1:0];
        REG_ACTIVE_LOW:  active_low  <= cfg_wdata[0];
        REG_BUTTON_MASK: button_mask <= cfg_wdata[PIN_W-1:0];
        REG_AXIS_ENABLE: axis_enable <= cfg_wdata[1:0];
        REG_X_CAL:       x_cal       <= cfg_wdata;
        REG_Y_CAL:       y_cal       <= cfg_wdata;
        REG_DEADZONE:    deadzone    <= cfg_wdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  bdn_debounce #(
    .BUTTONS (BUTTONS)
  ) u_debounce (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .now         (s_axis_tdata[TIME_W-1:0]),
    .pins        (s_axis_tdata[TIME_W+PIN_W-1:TIME_W]),
    .active_low  (active_low),
    .button_mask (button_mask),
    .debounce_ms (debounce_ms),
    .done        (deb_done),
    .status      (status)
  );

  bdn_axis u_axis (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .x_sample    (s_axis_tdata[82:71]),
    .y_sample    (s_axis_tdata[94:83]),
    .axis_enable (axis_enable),
    .x_cal       (x_cal),
    .y_cal       (y_cal),
    .deadzone    (deadzone),
    .done        (ax_done),
    .axis_x      (axis_x),
    .axis_y      (axis_y)
  );

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: if (s_axis_tvalid) state_next = CS_RUN;
      CS_RUN:  if (deb_seen && ax_seen) state_next = CS_PUT;
      CS_PUT:  if (!m_axis_tvalid || m_axis_tready) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      CS_IDLE: s_axis_tready = 1'b1;
      CS_PUT:  load_out = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  assign start = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CS_IDLE;
      deb_seen      <= 1'b0;
      ax_seen       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        deb_seen <= 1'b0;
        ax_seen  <= 1'b0;
      end else begin
        if (deb_done) deb_seen <= 1'b1;
        if (ax_done)  ax_seen  <= 1'b1;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {axis_y, axis_x, status.went_up, status.went_down, status.held};
    end
  end

endmodule

>>> hw/rtl/bdn_checker.sv
// ----------------------------------------------------------------------------
// bdn_checker: port-level checks for the debounce and axis core
// Watches the stream and result ports and flags impossible results.
// ----------------------------------------------------------------------------
module bdn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("tick taken while previous tick still in work");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result transfer changed");

  a_edges_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (((m_axis_tdata[15:8] & m_axis_tdata[23:16]) == 8'h00) &&
                       ((m_axis_tdata[15:8] & ~m_axis_tdata[7:0]) == 8'h00)))
    else $error("press and release edges disagree with held state");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (($signed(m_axis_tdata[39:24]) >= -16'sd16384) &&
                       ($signed(m_axis_tdata[39:24]) <= 16'sd16384) &&
                       ($signed(m_axis_tdata[55:40]) >= -16'sd16384) &&
                       ($signed(m_axis_tdata[55:40]) <= 16'sd16384)))
    else $error("axis value outside plus or minus one");

endmodule

bind button_debounce_and_axis_normalizer_core bdn_checker u_bdn_checker (.*);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the button debounce and axis normaliser core
// Streams ticks into the core in random bursts while the receiver stalls on
// its own pattern. A bit-exact predictor of the debounce lanes and the Q2.14
// axis scaling runs on every accepted tick. Each status transfer is checked
// field by field against the oldest prediction. Register settings change
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;
  import bdn_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int PHASES       = 8;
  localparam int PHASE_TICKS  = 116;
  localparam int TAIL_CYCLES  = 100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] joy_y;
    logic [SAMPLE_W-1:0] joy_x;
    logic [PIN_W-1:0]    pins;
    logic [TIME_W-1:0]   time_us;
  } tick_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_x;
    logic [PIN_W-1:0]         went_up;
    logic [PIN_W-1:0]         went_down;
    logic [PIN_W-1:0]         held;
  } status_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [95:0]       s_axis_tdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [55:0]       m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_addr = '0;
  logic [CAL_W-1:0]  cfg_wdata = '0;

  button_debounce_and_axis_normalizer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [MS_W-1:0]  db_ms;
  logic             low_active;
  logic [PIN_W-1:0] pin_mask;
  logic [1:0]       axes_on;
  logic [CAL_W-1:0] cal_x;
  logic [CAL_W-1:0] cal_y;
  logic [DZ_W-1:0]  dz_width;

  // predictor copy of the state
  logic [PIN_W-1:0]  raw_q;
  logic [TIME_W-1:0] changed_at [PIN_W];
  logic [PIN_W-1:0]  deb_now;
  logic [PIN_W-1:0]  deb_prev;
  logic signed [AXIS_W-1:0] pos_x;
  logic signed [AXIS_W-1:0] pos_y;

  tick_t   pending_ticks[$];
  status_t expected_status[$];
  tick_t   offered_tick;
  tick_t   next_tick;

  int errors = 0;
  int ticks_sent = 0;
  int status_checked = 0;
  int settings_used = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int run_left = 0;
  int stall_left = 0;
  int hold_cnt = 0;
  bit sender_gaps_on = 1'b0;
  bit receiver_stalls_on = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;

  function automatic logic signed [AXIS_W-1:0] axis_q214(logic [SAMPLE_W-1:0] sample,
                                                         logic [CAL_W-1:0] cal);
    int lo, mid, hi, s, span, delta, mag;
    bit neg;
    lo  = int'(cal[11:0]);
    mid = int'(cal[23:12]);
    hi  = int'(cal[35:24]);
    s   = int'(sample);
    if (s >= mid) begin
      span  = hi - mid;
      delta = s - mid;
      neg   = 1'b0;
    end else begin
      span  = mid - lo;
      delta = mid - s;
      neg   = 1'b1;
    end
    if (span <= 0) return '0;
    mag = (delta * 16384) / span;
    if (mag < int'(dz_width)) return '0;
    if (mag > 16384) mag = 16384;
    return neg ? AXIS_W'(-mag) : AXIS_W'(mag);
  endfunction

  function automatic status_t debounce_and_scale(tick_t tk);
    status_t st;
    logic [TIME_W-1:0] wait_us;
    logic [TIME_W-1:0] elapsed;
    logic pressed;
    wait_us = TIME_W'(db_ms) * TIME_W'(1000);
    for (int i = 0; i < PIN_W; i++) begin
      pressed = pin_mask[i] ? (low_active ? ~tk.pins[i] : tk.pins[i]) : 1'b0;
      elapsed = tk.time_us - changed_at[i];
      if (pressed != raw_q[i]) begin
        raw_q[i] = pressed;
        changed_at[i] = tk.time_us;
      end else if (elapsed >= wait_us) begin
        deb_prev[i] = deb_now[i];
        deb_now[i] = pressed;
      end
    end
    if (axes_on[0]) pos_x = axis_q214(tk.joy_x, cal_x);
    if (axes_on[1]) pos_y = axis_q214(tk.joy_y, cal_y);
    st.held      = deb_now;
    st.went_down = deb_now & ~deb_prev;
    st.went_up   = ~deb_now & deb_prev;
    st.axis_x    = pos_x;
    st.axis_y    = pos_y;
    return st;
  endfunction

  function automatic logic [CAL_W-1:0] rand_cal();
    logic [SAMPLE_W-1:0] a, b, c, t;
    a = SAMPLE_W'($urandom);
    b = SAMPLE_W'($urandom);
    c = SAMPLE_W'($urandom);
    case ($urandom_range(0, 5))
      0: return CAL_W'($urandom) | (CAL_W'($urandom_range(0, 15)) << 32);
      1: return {12'd4095, 12'd2048, 12'd0};
      default: begin
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        return {c, b, a};
      end
    endcase
  endfunction

  task automatic program_reg(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_DEBOUNCE_MS: db_ms      = value[MS_W-1:0];
      REG_ACTIVE_LOW:  low_active = value[0];
      REG_BUTTON_MASK: pin_mask   = value[PIN_W-1:0];
      REG_AXIS_ENABLE: axes_on    = value[1:0];
      REG_X_CAL:       cal_x      = value;
      REG_Y_CAL:       cal_y      = value;
      REG_DEADZONE:    dz_width   = value[DZ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tick(logic [TIME_W-1:0] t, logic [PIN_W-1:0] p,
                           logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y);
    tick_t tk;
    tk.time_us = t;
    tk.pins    = p;
    tk.joy_x   = x;
    tk.joy_y   = y;
    pending_ticks.push_back(tk);
  endtask

  task automatic wait_quiet();
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // sender: bursts of random length, random gaps between them when gaps are on
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status.push_back(debounce_and_scale(offered_tick));
        ticks_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          offered_tick = next_tick;
          s_axis_tdata <= {1'b0, next_tick};
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= sender_gaps_on ? $urandom_range(0, 160) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_cnt <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!receiver_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      m_axis_tready <= 1'b1;
    end else begin
      run_left <= $urandom_range(0, 150);
      stall_left <= $urandom_range(0, 120);
      m_axis_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    status_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected status transfer, expected none actual %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_status.pop_front();
        check_field("held", 16'(want.held), 16'(got.held));
        check_field("went_down", 16'(want.went_down), 16'(got.went_down));
        check_field("went_up", 16'(want.went_up), 16'(got.went_up));
        check_field("axis_x", want.axis_x, got.axis_x);
        check_field("axis_y", want.axis_y, got.axis_y);
        status_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] stim_time;
    logic [PIN_W-1:0]  stim_pins;
    longint unsigned   wait_us;
    longint unsigned   step;

    db_ms      = DEBOUNCE_RST;
    low_active = ACTIVE_LOW_RST;
    pin_mask   = MASK_RST;
    axes_on    = AXIS_EN_RST;
    cal_x      = CAL_RST;
    cal_y      = CAL_RST;
    dz_width   = DEADZONE_RST;
    raw_q      = '0;
    deb_now    = '0;
    deb_prev   = '0;
    pos_x      = '0;
    pos_y      = '0;
    for (int i = 0; i < PIN_W; i++) changed_at[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: release, press, early sample, settle, partial release
    send_tick(63'd0,     8'hFF, 12'd0,    12'd4095);
    send_tick(63'd25000, 8'hFF, 12'd4095, 12'd0);
    send_tick(63'd30000, 8'h00, 12'd2048, 12'd2048);
    send_tick(63'd40000, 8'h00, 12'd1,    12'd1);
    send_tick(63'd50000, 8'h00, 12'd100,  12'd200);
    send_tick(63'd60000, 8'h00, 12'd300,  12'd400);
    send_tick(63'd61000, 8'hA5, 12'd500,  12'd600);
    send_tick(63'd90000, 8'hA5, 12'd700,  12'd800);
    wait_quiet();

    // both axes on, no deadzone, zero debounce, high-active, half the pins
    program_reg(REG_AXIS_ENABLE, 36'd3);
    program_reg(REG_X_CAL, {12'd4000, 12'd2000, 12'd100});
    program_reg(REG_Y_CAL, {12'd4095, 12'd2048, 12'd0});
    program_reg(REG_DEADZONE, 36'd0);
    program_reg(REG_DEBOUNCE_MS, 36'd0);
    program_reg(REG_ACTIVE_LOW, 36'd0);
    program_reg(REG_BUTTON_MASK, 36'h0F);
    program_reg(REG_UNUSED, 36'hFFFFFFFFF);
    end_writes();
    send_tick(63'd100000, 8'h55, 12'd0,    12'd4095);
    send_tick(63'd100001, 8'hAA, 12'd4095, 12'd0);
    send_tick(63'd100002, 8'hAA, 12'd2000, 12'd2048);
    send_tick(63'd100003, 8'hFF, 12'd2001, 12'd2049);
    send_tick(63'd100004, 8'h00, 12'd1999, 12'd2047);
    send_tick(63'd100005, 8'h00, 12'd100,  12'd1);
    wait_quiet();

    // longest debounce, counter wrap, time going backwards, empty X range
    program_reg(REG_DEBOUNCE_MS, 36'd65535);
    program_reg(REG_ACTIVE_LOW, 36'd1);
    program_reg(REG_BUTTON_MASK, 36'hFF);
    program_reg(REG_DEADZONE, 36'd16384);
    program_reg(REG_X_CAL, {12'd2048, 12'd2048, 12'd2048});
    program_reg(REG_AXIS_ENABLE, 36'd1);
    end_writes();
    send_tick(63'h7FFF_FFFF_FFFF_FC18, 8'h0F, 12'd4095, 12'd0);
    send_tick(63'd65534000, 8'h0F, 12'd0, 12'd4095);
    send_tick(63'd100, 8'hF0, 12'd2048, 12'd1000);
    send_tick(63'd50,  8'hF0, 12'd2047, 12'd3000);
    wait_quiet();

    stim_time = 63'd0;
    stim_pins = 8'hFF;
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_gaps_on     = (ph != 0) && (ph != 2);
      receiver_stalls_on = (ph != 0);
      case (ph)
        0: begin
          program_reg(REG_DEBOUNCE_MS, 36'd65535);
          program_reg(REG_ACTIVE_LOW, 36'd1);
          program_reg(REG_BUTTON_MASK, 36'hFF);
          program_reg(REG_AXIS_ENABLE, 36'd3);
          program_reg(REG_X_CAL, 36'hFFFFFFFFF);
          program_reg(REG_Y_CAL, {12'd4095, 12'd2048, 12'd0});
          program_reg(REG_DEADZONE, 36'd32767);
        end
        1: begin
          program_reg(REG_DEBOUNCE_MS, 36'd0);
          program_reg(REG_ACTIVE_LOW, 36'd0);
          program_reg(REG_BUTTON_MASK, 36'd0);
          program_reg(REG_AXIS_ENABLE, 36'd0);
          program_reg(REG_X_CAL, 36'd0);
          program_reg(REG_Y_CAL, 36'd0);
          program_reg(REG_DEADZONE, 36'd0);
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       program_reg(REG_DEBOUNCE_MS, 36'd65535);
            1:       program_reg(REG_DEBOUNCE_MS, 36'd0);
            default: program_reg(REG_DEBOUNCE_MS, CAL_W'($urandom_range(1, 50)));
          endcase
          program_reg(REG_ACTIVE_LOW, CAL_W'($urandom_range(0, 1)));
          program_reg(REG_BUTTON_MASK, CAL_W'($urandom_range(0, 255)));
          program_reg(REG_AXIS_ENABLE, CAL_W'($urandom_range(0, 3)));
          program_reg(REG_X_CAL, rand_cal());
          program_reg(REG_Y_CAL, rand_cal());
          case ($urandom_range(0, 5))
            0:       program_reg(REG_DEADZONE, 36'd16384);
            1:       program_reg(REG_DEADZONE, CAL_W'($urandom_range(0, 32767)));
            default: program_reg(REG_DEADZONE, CAL_W'($urandom_range(0, 3000)));
          endcase
        end
      endcase
      program_reg(REG_UNUSED, CAL_W'($urandom));
      end_writes();
      if (ph == 2) long_hold_req = 1'b1;

      wait_us = longint'(db_ms) * 1000;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        case ($urandom_range(0, 19))
          0: begin
            // noise: jump anywhere, random pins
            stim_time = TIME_W'({$urandom, $urandom});
            stim_pins = PIN_W'($urandom);
          end
          1: begin
            stim_time = 63'h7FFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 2000));
          end
          default: begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: step = $urandom_range(0, 32'(wait_us / 2));
              4:          step = (wait_us > 0) ? wait_us - 1 : 0;
              5:          step = wait_us;
              6:          step = wait_us + 1;
              default:    step = $urandom_range(0, 32'(2 * wait_us + 1000));
            endcase
            stim_time = stim_time + TIME_W'(step);
            if ($urandom_range(0, 3) == 0) stim_pins = stim_pins ^ PIN_W'($urandom);
          end
        endcase
        send_tick(stim_time, stim_pins, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      end
      wait_quiet();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d ticks and %0d status checks over %0d register settings,",
             ticks_sent, status_checked, settings_used);
    $display("with bursty input, output stalls, a long output hold-off and time wrap.");
    if (errors == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
